// ===== rtl/core/tsyn_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP SYN header generator package
// Shared types, constants and the header word selector.
// ----------------------------------------------------------------------------
package tsyn_pkg;

  localparam int unsigned HDR_WORDS   = 20;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] WINDOW_RESET = 16'd64495;
  localparam logic [15:0] WORD_VER_IHL = 16'h4500;
  localparam logic [15:0] IP_TOTAL_LEN = 16'd40;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
  localparam logic [15:0] WORD_OFF_SYN = 16'h5002;

  // Header word positions
  localparam logic [4:0] WIDX_VER_IHL   = 5'd0;
  localparam logic [4:0] WIDX_TOTAL_LEN = 5'd1;
  localparam logic [4:0] WIDX_TTL_PROTO = 5'd4;
  localparam logic [4:0] WIDX_SRC_HI    = 5'd6;
  localparam logic [4:0] WIDX_SRC_LO    = 5'd7;
  localparam logic [4:0] WIDX_DST_HI    = 5'd8;
  localparam logic [4:0] WIDX_DST_LO    = 5'd9;
  localparam logic [4:0] WIDX_SPORT     = 5'd10;
  localparam logic [4:0] WIDX_DPORT     = 5'd11;
  localparam logic [4:0] WIDX_OFF_FLAGS = 5'd16;
  localparam logic [4:0] WIDX_WINDOW    = 5'd17;
  localparam logic [4:0] WIDX_CSUM      = 5'd18;
  localparam logic [4:0] WIDX_LAST      = 5'd19;

  // Sum of up to ten 16-bit words fits in 20 bits
  localparam int unsigned ACC_W = 20;

  typedef struct packed {
    logic [31:0] ip_saddr;
    logic [31:0] ip_daddr;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [7:0]  time_to_live;
  } req_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [4:0]  word_index;
    logic        last;
  } res_t;

  typedef struct packed {
    req_t        req;
    logic [15:0] window;
    logic [15:0] csum;
  } job_t;

  function automatic logic [15:0] hdr_word(input job_t job, input logic [4:0] idx);
    logic [15:0] w;
    w = 16'h0000;
    case (idx)
      WIDX_VER_IHL:   w = WORD_VER_IHL;
      WIDX_TOTAL_LEN: w = IP_TOTAL_LEN;
      WIDX_TTL_PROTO: w = {job.req.time_to_live, PROTO_TCP};
      WIDX_SRC_HI:    w = job.req.ip_saddr[31:16];
      WIDX_SRC_LO:    w = job.req.ip_saddr[15:0];
      WIDX_DST_HI:    w = job.req.ip_daddr[31:16];
      WIDX_DST_LO:    w = job.req.ip_daddr[15:0];
      WIDX_SPORT:     w = job.req.tcp_sport;
      WIDX_DPORT:     w = job.req.tcp_dport;
      WIDX_OFF_FLAGS: w = WORD_OFF_SYN;
      WIDX_WINDOW:    w = job.window;
      WIDX_CSUM:      w = job.csum;
      default:        w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/tcp_syn_header_generator.sv =====
// A request passes the front-end register, a queue slot and the job register before
// its first word is registered at the outputs. Throughput: one word per cycle while
// words are popped; the word sequencer sets this; requests are taken while it runs.
// Reset (rst_n low, synchronous): queues empty, window register back to 64495.
// ----------------------------------------------------------------------------
// TCP SYN header generator
// Builds a 40-byte IPv4 + TCP SYN header with TCP checksum, one word per beat.
// ----------------------------------------------------------------------------
module tcp_syn_header_generator
  import tsyn_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  req_t        in_req,
  output logic        out_empty,
  input  logic        out_pop,
  output res_t        out_hdr
);

  logic q_push, q_full, q_pop, q_valid;
  job_t q_wdata, q_rdata;

  tsyn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  tsyn_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_rdata (q_rdata)
  );

  tsyn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_hdr   (out_hdr)
  );

endmodule

// ===== rtl/core/tsyn_front.sv =====
// ----------------------------------------------------------------------------
// TCP SYN front end
// Holds the window register, takes requests and sums the checksum words.
// ----------------------------------------------------------------------------
module tsyn_front
  import tsyn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  req_t        in_req,
  output logic        q_push,
  input  logic        q_full,
  output job_t        q_wdata
);

  logic [15:0]      window_r;
  logic             fr_valid_r, fr_valid_nxt;
  req_t             req_r;
  logic [15:0]      win_snap_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic             accept;

  assign q_push  = fr_valid_r && !q_full;
  assign in_full = fr_valid_r && q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    acc_nxt = ACC_W'(in_req.ip_saddr[31:16]) + ACC_W'(in_req.ip_saddr[15:0])
            + ACC_W'(in_req.ip_daddr[31:16]) + ACC_W'(in_req.ip_daddr[15:0])
            + ACC_W'(in_req.tcp_sport) + ACC_W'(in_req.tcp_dport)
            + ACC_W'(window_r) + ACC_W'(WORD_OFF_SYN)
            + ACC_W'(PROTO_TCP) + ACC_W'(TCP_HDR_LEN);
  end

  // fold twice, then invert
  assign fold1 = 17'(acc_r[ACC_W-1:16]) + 17'(acc_r[15:0]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

  always_comb begin
    q_wdata.req    = req_r;
    q_wdata.window = win_snap_r;
    q_wdata.csum   = ~fold2[15:0];
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RESET;
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_req;
      win_snap_r <= window_r;
      acc_r      <= acc_nxt;
    end
  end

endmodule

// ===== rtl/core/tsyn_queue.sv =====
// ----------------------------------------------------------------------------
// TCP SYN job queue
// Small FIFO of prepared header jobs between front end and word sequencer.
// ----------------------------------------------------------------------------
module tsyn_queue
  import tsyn_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  output logic q_full,
  input  job_t q_wdata,
  input  logic q_pop,
  output logic q_valid,
  output job_t q_rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_rdata = slot_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// ===== rtl/core/tsyn_back.sv =====
// ----------------------------------------------------------------------------
// TCP SYN word sequencer
// Walks one job through its twenty header words into the output register.
// ----------------------------------------------------------------------------
module tsyn_back
  import tsyn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  output logic q_pop,
  input  logic q_valid,
  input  job_t q_rdata,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_hdr
);

  job_t       cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_r;
  logic       beat_taken, load, at_last;

  assign beat_taken = out_pop && out_valid_r;
  assign load       = cur_valid_r && (!out_valid_r || beat_taken);
  assign at_last    = (cnt_r == WIDX_LAST);
  assign q_pop      = q_valid && (!cur_valid_r || (load && at_last));
  assign out_empty  = !out_valid_r;
  assign out_hdr    = out_r;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (at_last) begin
        cnt_nxt       = '0;
        cur_valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (beat_taken) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (load) begin
      out_r.header_word <= hdr_word(cur_r, cnt_r);
      out_r.word_index  <= cnt_r;
      out_r.last        <= at_last;
    end
  end

endmodule

// ===== test/tb_tcp_syn_header_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP SYN header generator testbench
// Sends address/port/TTL requests through the input queue port and checks
// every 16-bit header word against an in-bench header and checksum
// calculation. Covers the window register, the field extremes and the
// zero-checksum case. Random request streams run with random idling on both, one
// or neither side.
// ----------------------------------------------------------------------------
module tb_tcp_syn_header_generator;
  import tsyn_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_push;
  logic        in_full;
  req_t        in_req;
  logic        out_empty;
  logic        out_pop = 1'b0;
  res_t        out_hdr;

  res_t        expected_words[$];
  logic [15:0] window_setting;
  bit          src_idle_on;
  bit          sink_idle_on;
  int          sink_stall;
  int          error_count;
  int          words_checked;
  int          reqs_sent;
  int          zero_csum_reqs;
  int          windows_used;

  tcp_syn_header_generator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_req   (in_req),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_hdr  (out_hdr)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Ones' complement sum over pseudo header and TCP header, folded twice.
  function automatic logic [15:0] syn_checksum(input req_t r, input logic [15:0] win);
    logic [31:0] acc;
    acc = 32'(r.ip_saddr[31:16]) + 32'(r.ip_saddr[15:0])
        + 32'(r.ip_daddr[31:16]) + 32'(r.ip_daddr[15:0])
        + 32'(PROTO_TCP) + 32'(TCP_HDR_LEN)
        + 32'(r.tcp_sport) + 32'(r.tcp_dport)
        + 32'(WORD_OFF_SYN) + 32'(win);
    acc = (acc >> 16) + (acc & 32'h0000ffff);
    acc = acc + (acc >> 16);
    return ~acc[15:0];
  endfunction

  function automatic void queue_header_words(input req_t r);
    logic [15:0] w [HDR_WORDS];
    res_t        beat;
    for (int i = 0; i < HDR_WORDS; i++) w[i] = 16'h0000;
    w[0]  = WORD_VER_IHL;
    w[1]  = IP_TOTAL_LEN;
    w[4]  = {r.time_to_live, PROTO_TCP};
    w[6]  = r.ip_saddr[31:16];
    w[7]  = r.ip_saddr[15:0];
    w[8]  = r.ip_daddr[31:16];
    w[9]  = r.ip_daddr[15:0];
    w[10] = r.tcp_sport;
    w[11] = r.tcp_dport;
    w[16] = WORD_OFF_SYN;
    w[17] = window_setting;
    w[18] = syn_checksum(r, window_setting);
    if (w[18] == 16'h0000) zero_csum_reqs++;
    for (int i = 0; i < HDR_WORDS; i++) begin
      beat.header_word = w[i];
      beat.word_index  = 5'(i);
      beat.last        = (i == HDR_WORDS - 1);
      expected_words.push_back(beat);
    end
  endfunction

  // Pick the destination port that makes the sum fold to all ones.
  function automatic req_t with_zero_checksum(input req_t r);
    r.tcp_dport = 16'h0000;
    r.tcp_dport = syn_checksum(r, window_setting);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.ip_saddr     = $urandom();
    r.ip_daddr     = $urandom();
    r.tcp_sport    = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 65535));
    r.tcp_dport    = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
    r.time_to_live = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) r = with_zero_checksum(r);
    return r;
  endfunction

  task automatic send_header_req(input req_t r);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req  <= r;
    do @(posedge clk); while (in_full);
    queue_header_words(r);
    reqs_sent++;
  endtask

  // Hold the sender until every header word is back.
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    window_setting  = value;
    windows_used++;
  endtask

  // Result side: check the beat, then pick the next pop value.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected header word %h idx %0d last %b",
                   out_hdr.header_word, out_hdr.word_index, out_hdr.last);
      end else begin
        res_t want;
        want = expected_words.pop_front();
        if (out_hdr.header_word !== want.header_word ||
            out_hdr.word_index !== want.word_index || out_hdr.last !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display({"header mismatch: expected word %h idx %0d last %b, ",
                      "got word %h idx %0d last %b"},
                     want.header_word, want.word_index, want.last,
                     out_hdr.header_word, out_hdr.word_index, out_hdr.last);
        end
      end
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (sink_idle_on && sink_stall == 0 && $urandom_range(0, 9) == 0)
        sink_stall = $urandom_range(1, 9);
      if (sink_stall > 0) begin
        out_pop <= 1'b0;
        sink_stall--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic test_reset_window();
    // no write yet: the reset window must appear
    send_header_req(rand_req());
    send_header_req(with_zero_checksum(rand_req()));
    drain_results();
  endtask

  task automatic test_field_extremes();
    req_t r;
    r = '0;
    send_header_req(r);
    r = '1;
    send_header_req(r);
    r = '{ip_saddr: 32'haaaaaaaa, ip_daddr: 32'h55555555, tcp_sport: 16'haaaa,
          tcp_dport: 16'h5555, time_to_live: 8'haa};
    send_header_req(r);
    r = '{ip_saddr: 32'h55555555, ip_daddr: 32'haaaaaaaa, tcp_sport: 16'h5555,
          tcp_dport: 16'haaaa, time_to_live: 8'h55};
    send_header_req(r);
    r = '{ip_saddr: 32'hffffffff, ip_daddr: 32'h00000000, tcp_sport: 16'h0000,
          tcp_dport: 16'hffff, time_to_live: 8'h00};
    send_header_req(r);
    r = '{ip_saddr: 32'h00000000, ip_daddr: 32'hffffffff, tcp_sport: 16'hffff,
          tcp_dport: 16'h0000, time_to_live: 8'hff};
    send_header_req(r);
    r = '{ip_saddr: 32'hc0a80001, ip_daddr: 32'h0a000001, tcp_sport: 16'd49152,
          tcp_dport: 16'd80, time_to_live: 8'd64};
    send_header_req(r);
    drain_results();
  endtask

  task automatic test_zero_checksum();
    req_t r;
    r = '1;
    send_header_req(with_zero_checksum(r));
    r = '0;
    send_header_req(with_zero_checksum(r));
    send_header_req(with_zero_checksum(rand_req()));
    drain_results();
  endtask

  task automatic test_window_settings();
    logic [15:0] wins [4];
    wins = '{16'h0000, 16'hffff, 16'h8001, WINDOW_RESET};
    foreach (wins[k]) begin
      write_window(wins[k]);
      send_header_req(rand_req());
      send_header_req(with_zero_checksum(rand_req()));
      drain_results();
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       write_window(16'h0000);
        2:       write_window(16'hffff);
        default: write_window(16'($urandom_range(0, 65535)));
      endcase
      // last phase runs back to back on both sides
      src_idle_on  = (ph != 2 && ph != 4);
      sink_idle_on = (ph != 3 && ph != 4);
      for (int n = 0; n < 90; n++) send_header_req(rand_req());
      drain_results();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 16'h0000;
    in_push        <= 1'b0;
    in_req         <= '0;
    window_setting  = WINDOW_RESET;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    sink_stall      = 0;
    error_count     = 0;
    words_checked   = 0;
    reqs_sent       = 0;
    zero_csum_reqs  = 0;
    windows_used    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_field_extremes();
    test_zero_checksum();
    test_window_settings();
    test_random_traffic();

    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      error_count++;
      $display("%0d header words never arrived", expected_words.size());
    end
    $display("sent %0d SYN requests, checked %0d header words", reqs_sent, words_checked);
    $display("%0d window writes, %0d requests with a zero checksum", windows_used,
             zero_csum_reqs);
    if (error_count == 0) begin
      $display("[tcp_syn_header_generator] OK");
    end else begin
      $display("%0d errors", error_count);
      $display("[tcp_syn_header_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("timeout");
    $display("[tcp_syn_header_generator] ERROR");
    $finish;
  end

endmodule
